>>> hdl/fqkr_pkg.sv
// Shared types and constants for the keyed-removal FIFO queue.
// Used by the cell row, the top level and the port checker; depends on nothing.
package fqkr_pkg;

    localparam int KEY_PORT_BITS = 16;
    localparam int COUNT_PORT_BITS = 5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [KEY_PORT_BITS-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                 status;
        logic [KEY_PORT_BITS-1:0]   served_key;
        logic [COUNT_PORT_BITS-1:0] entry_count;
    } t_out_item;

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
        logic capture;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_REMOVE
    } t_state;

endpackage

>>> hdl/fqkr_cell.sv
// One storage cell of the queue row: holds a key, compares it with the search key
// and takes its right neighbor's key when the row closes up. Uses fqkr_pkg.
module fqkr_cell #(
    parameter int IDX   = 0,
    parameter int KEY_W = 16,
    parameter int CNT_W = 5
) (
    input  logic                 i_clk,
    input  fqkr_pkg::t_cell_ctl  i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [KEY_W-1:0]     i_next_data,
    input  logic                 i_hit,
    output logic [KEY_W-1:0]     o_data,
    output logic                 o_hit
);

    logic [KEY_W-1:0] r_data;
    logic             r_match;
    logic             occupied;

    assign occupied = i_count > CNT_W'(IDX);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= occupied && (r_data == i_key);
        end
        if (i_ctl.enq && (i_count == CNT_W'(IDX))) begin
            r_data <= i_key;
        end else if (i_ctl.deq || (i_ctl.rem && (i_hit || r_match))) begin
            r_data <= i_next_data;
        end
    end

    // A cell closes up when it or any cell nearer the head held the match.
    assign o_hit  = i_hit | r_match;
    assign o_data = r_data;

endmodule

>>> hdl/fifo_queue_with_keyed_removal_core.sv
// Bounded FIFO queue of keys with removal of the first matching key; uses fqkr_pkg, fqkr_cell.
// Enqueue, dequeue, unused opcodes and a remove on an empty queue: result registered, in the
// cycle after acceptance, one transaction per cycle.
// Remove on a nonempty queue: the cells register their compare results first, then the
// ST_REMOVE state, with busy high for one cycle, registers the result.
// Synchronous active-low reset empties the queue; each result shows for one cycle only.
module fifo_queue_with_keyed_removal_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fqkr_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output fqkr_pkg::t_out_item o_result
);

    localparam int KEY_W = (KEY_BITS < fqkr_pkg::KEY_PORT_BITS) ? KEY_BITS
                                                                : fqkr_pkg::KEY_PORT_BITS;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fqkr_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_strobe, n_strobe;
    fqkr_pkg::t_out_item r_result, n_result;
    fqkr_pkg::t_cell_ctl ctl;

    logic [KEY_W-1:0] key_in;
    logic [KEY_W-1:0] cell_data [0:QUEUE_DEPTH];
    logic             hit       [0:QUEUE_DEPTH];
    logic             accept;
    logic             full;
    logic             empty;

    assign key_in = i_item.key[KEY_W-1:0];
    assign busy   = (r_state == fqkr_pkg::ST_REMOVE);
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);

    assign cell_data[QUEUE_DEPTH] = '0;
    assign hit[0]                 = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        fqkr_cell #(
            .IDX   (g),
            .KEY_W (KEY_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_key       (key_in),
            .i_next_data (cell_data[g+1]),
            .i_hit       (hit[g]),
            .o_data      (cell_data[g]),
            .o_hit       (hit[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_strobe = 1'b0;
        ctl      = '0;
        n_result.status     = fqkr_pkg::STAT_OK;
        n_result.served_key = '0;
        case (r_state)
            fqkr_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_item.opcode)
                        fqkr_pkg::OP_ENQUEUE: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_result.status = fqkr_pkg::STAT_FULL;
                            end else begin
                                ctl.enq = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        fqkr_pkg::OP_DEQUEUE: begin
                            n_strobe = 1'b1;
                            if (empty) begin
                                n_result.status = fqkr_pkg::STAT_EMPTY;
                            end else begin
                                ctl.deq             = 1'b1;
                                n_count             = r_count - 1'b1;
                                n_result.served_key =
                                    fqkr_pkg::KEY_PORT_BITS'(cell_data[0]);
                            end
                        end
                        fqkr_pkg::OP_REMOVE: begin
                            if (empty) begin
                                n_strobe        = 1'b1;
                                n_result.status = fqkr_pkg::STAT_EMPTY;
                            end else begin
                                ctl.capture = 1'b1;
                                n_state     = fqkr_pkg::ST_REMOVE;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            fqkr_pkg::ST_REMOVE: begin
                n_state  = fqkr_pkg::ST_IDLE;
                n_strobe = 1'b1;
                if (hit[QUEUE_DEPTH]) begin
                    ctl.rem = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    n_result.status = fqkr_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
                n_state = fqkr_pkg::ST_IDLE;
            end
        endcase
        n_result.entry_count = fqkr_pkg::COUNT_PORT_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fqkr_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> hdl/fqkr_checker.sv
// Port-level checker for the keyed-removal FIFO queue, bound to the top level.
// Uses fqkr_pkg for opcode and status codes.
module fqkr_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input fqkr_pkg::t_in_item  i_item,
    input logic                o_strobe,
    input fqkr_pkg::t_out_item o_result
);

    // Every transaction other than a remove answers in the very next cycle.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode != fqkr_pkg::OP_REMOVE)) |=> o_strobe)
        else $error("missing result after a single-cycle transaction");

    // The busy cycle of a remove ends with its result and frees the port.
    a_remove_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("remove did not complete after its busy cycle");

    // Only a successful dequeue carries a key.
    a_served_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != fqkr_pkg::STAT_OK)) |-> (o_result.served_key == '0))
        else $error("served key set on a failed transaction");

    // A full report always shows the queue at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == fqkr_pkg::STAT_FULL))
            |-> (o_result.entry_count == fqkr_pkg::COUNT_PORT_BITS'(QUEUE_DEPTH)))
        else $error("full status with a count below capacity");

endmodule

bind fifo_queue_with_keyed_removal_core fqkr_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqkr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_keyed_removal_core, built on fqkr_pkg.
// A queue-driven driver and a clocked monitor check each result against a behavioral key queue.
module testbench;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 1725;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                click_unused_guard;
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    fqkr_pkg::t_in_item  i_item = '0;
    logic                o_strobe;
    fqkr_pkg::t_out_item o_result;

    fqkr_pkg::t_in_item                 pending_items[$];
    fqkr_pkg::t_out_item                awaited_results[$];
    logic [fqkr_pkg::KEY_PORT_BITS-1:0] model_keys[DEPTH];
    int                                 model_held = 0;
    int                                 total_items = 0;
    int                                 taken_count = 0;
    int                                 stall_cycles = 0;
    int                                 error_count = 0;
    bit                                 item_taken = 1'b0;

    assign click_unused_guard = 1'b0;

    fifo_queue_with_keyed_removal_core #(
        .QUEUE_DEPTH(DEPTH),
        .KEY_BITS   (fqkr_pkg::KEY_PORT_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one operation to the behavioral queue and returns the result it should produce.
    function automatic fqkr_pkg::t_out_item apply_queue_op(fqkr_pkg::t_in_item op_item);
        fqkr_pkg::t_out_item res;
        int                  pos;
        res = '0;
        res.status = fqkr_pkg::STAT_OK;
        case (op_item.opcode)
            fqkr_pkg::OP_ENQUEUE: begin
                if (model_held >= DEPTH) begin
                    res.status = fqkr_pkg::STAT_FULL;
                end else begin
                    model_keys[model_held] = op_item.key;
                    model_held++;
                end
            end
            fqkr_pkg::OP_DEQUEUE: begin
                if (model_held == 0) begin
                    res.status = fqkr_pkg::STAT_EMPTY;
                end else begin
                    res.served_key = model_keys[0];
                    for (int i = 0; i < model_held - 1; i++) model_keys[i] = model_keys[i + 1];
                    model_held--;
                end
            end
            fqkr_pkg::OP_REMOVE: begin
                if (model_held == 0) begin
                    res.status = fqkr_pkg::STAT_EMPTY;
                end else begin
                    pos = model_held;
                    for (int i = 0; i < model_held; i++) begin
                        if (pos == model_held && model_keys[i] == op_item.key) pos = i;
                    end
                    if (pos == model_held) begin
                        res.status = fqkr_pkg::STAT_NOT_FOUND;
                    end else begin
                        for (int i = pos; i < model_held - 1; i++) model_keys[i] = model_keys[i + 1];
                        model_held--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = fqkr_pkg::COUNT_PORT_BITS'(model_held);
        return res;
    endfunction

    task automatic push_item(logic [1:0] op, logic [fqkr_pkg::KEY_PORT_BITS-1:0] key);
        fqkr_pkg::t_in_item it;
        it.opcode = op;
        it.key = key;
        pending_items.push_back(it);
    endtask

    // The sender idles a share of cycles that depends on how far the run has come.
    always @(negedge i_clk) begin
        int idle_pct;
        if (!i_rst_n || pending_items.size() == 0) begin
            start <= 1'b0;
        end else begin
            if (taken_count < total_items / 3) idle_pct = 25;
            else if (taken_count < 2 * total_items / 3) idle_pct = 60;
            else idle_pct = 0;
            if ((start && !item_taken) || $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        fqkr_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (awaited_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got %p", $time, o_result);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_result.status);
                    end
                    if (o_result.served_key !== want.served_key) begin
                        error_count++;
                        $display("%0t: served_key expected %h, got %h",
                                 $time, want.served_key, o_result.served_key);
                    end
                    if (o_result.entry_count !== want.entry_count) begin
                        error_count++;
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.entry_count, o_result.entry_count);
                    end
                end
            end
            item_taken = start && !busy;
            if (item_taken) begin
                awaited_results.push_back(apply_queue_op(pending_items.pop_front()));
                taken_count++;
            end
            if (o_strobe || item_taken) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [fqkr_pkg::KEY_PORT_BITS-1:0] fill_keys[DEPTH];
        logic [fqkr_pkg::KEY_PORT_BITS-1:0] recent_keys[$];
        logic [fqkr_pkg::KEY_PORT_BITS-1:0] key;
        logic [1:0]                         op;
        int                                 fill_bias;
        int                                 roll;

        fill_keys = '{
            16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h1234, 16'hAAAA, 16'h5555, 16'h00FF,
            16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'h7FFF, 16'h8000, 16'h0001, 16'hC3A5
        };

        // Operations on an empty queue, then a full queue with a duplicated key.
        push_item(fqkr_pkg::OP_DEQUEUE, 16'h0000);
        push_item(fqkr_pkg::OP_REMOVE, 16'h0000);
        push_item(OP_UNUSED, 16'hFFFF);
        foreach (fill_keys[i]) push_item(fqkr_pkg::OP_ENQUEUE, fill_keys[i]);
        push_item(fqkr_pkg::OP_ENQUEUE, 16'h7777);
        push_item(fqkr_pkg::OP_REMOVE, 16'h9999);
        push_item(fqkr_pkg::OP_REMOVE, 16'h1234);
        push_item(fqkr_pkg::OP_REMOVE, 16'hC3A5);
        push_item(fqkr_pkg::OP_REMOVE, 16'h0000);
        push_item(fqkr_pkg::OP_DEQUEUE, 16'hFFFF);
        push_item(OP_UNUSED, 16'h0000);

        // Alternate between filling and draining so both full and empty are reached often.
        fill_bias = 30;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 48 == 0) fill_bias = (fill_bias == 70) ? 30 : 70;
            roll = $urandom_range(99);
            if (roll < 3) op = OP_UNUSED;
            else if (roll < fill_bias) op = fqkr_pkg::OP_ENQUEUE;
            else if (roll < fill_bias + (100 - fill_bias) / 2) op = fqkr_pkg::OP_DEQUEUE;
            else op = fqkr_pkg::OP_REMOVE;
            key = fqkr_pkg::KEY_PORT_BITS'($urandom);
            if (op == fqkr_pkg::OP_ENQUEUE) begin
                if ($urandom_range(99) < 40) key = fqkr_pkg::KEY_PORT_BITS'($urandom_range(7));
                recent_keys.push_back(key);
                if (recent_keys.size() > 24) void'(recent_keys.pop_front());
            end else if (op == fqkr_pkg::OP_REMOVE && recent_keys.size() != 0
                         && $urandom_range(99) < 70) begin
                key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            end
            push_item(op, key);
        end
        total_items = pending_items.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && !click_unused_guard) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
